@@ design/lr_pkg.sv @@
// ============================================================================
// lr_pkg: shared types and codes of the line rasterizer
// Command flags passed from the front end to the back end, the back-end
// sequencer states and the request and mode codes.
// ============================================================================
package lr_pkg;

    // Request kinds carried in the input tuser bit.
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Values of the line algorithm register.
    localparam logic ALG_DIRECT = 1'b0;
    localparam logic ALG_DDA    = 1'b1;

    // Classification of one queued request.
    typedef struct packed {
        logic is_start;  // Request loads a new line.
        logic zero_len;  // Both endpoints coincide.
        logic x_major;   // |dy| <= |dx|: x is the stepping axis.
        logic x_neg;     // x_end < x_start.
        logic y_neg;     // y_end < y_start.
    } t_cmd_flags;

    // Back-end sequencer states.
    typedef enum logic [0:0] {
        ST_READY,
        ST_DIVIDE
    } t_back_state;

endpackage

@@ design/lr_front.sv @@
// ============================================================================
// lr_front: request intake and classification
// Takes input requests, works out deltas, magnitudes, step count and line
// class, and holds the result in a two-entry command queue for the back end.
// ============================================================================
module lr_front
    import lr_pkg::*;
#(
    parameter int COORD_WIDTH = 10,
    localparam int IN_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_kind,
    input  logic [IN_W-1:0]        i_data,  // x_start, y_start, x_end, y_end, zero fill
    output logic                   o_cmd_valid,
    input  logic                   i_cmd_pop,
    output t_cmd_flags             o_cmd_flags,
    output logic [COORD_WIDTH-1:0] o_x0,
    output logic [COORD_WIDTH-1:0] o_y0,
    output logic [COORD_WIDTH-1:0] o_adx,
    output logic [COORD_WIDTH-1:0] o_ady,
    output logic [COORD_WIDTH-1:0] o_steps
);

    localparam int CW = COORD_WIDTH;

    logic [CW-1:0] x0, y0, x1, y1;
    logic [CW-1:0] adx, ady, steps;
    t_cmd_flags    flags;
    logic          push;

    t_cmd_flags    r_flags [2];
    logic [CW-1:0] r_x0    [2];
    logic [CW-1:0] r_y0    [2];
    logic [CW-1:0] r_adx   [2];
    logic [CW-1:0] r_ady   [2];
    logic [CW-1:0] r_steps [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_count;

    // Unpack the endpoints.
    assign x0 = i_data[0*CW +: CW];
    assign y0 = i_data[1*CW +: CW];
    assign x1 = i_data[2*CW +: CW];
    assign y1 = i_data[3*CW +: CW];

    // Classify the line: magnitudes, directions and the stepping axis.
    always_comb begin
        flags.is_start = (i_kind == KIND_START);
        flags.x_neg    = (x1 < x0);
        flags.y_neg    = (y1 < y0);
        adx            = flags.x_neg ? (x0 - x1) : (x1 - x0);
        ady            = flags.y_neg ? (y0 - y1) : (y1 - y0);
        steps          = (adx > ady) ? adx : ady;
        flags.zero_len = (steps == '0);
        flags.x_major  = (ady <= adx);
    end

    assign o_ready = (r_count != 2'd2);
    assign push    = i_valid && o_ready;

    // Command queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_flags[r_wr_ptr] <= flags;
            r_x0[r_wr_ptr]    <= x0;
            r_y0[r_wr_ptr]    <= y0;
            r_adx[r_wr_ptr]   <= adx;
            r_ady[r_wr_ptr]   <= ady;
            r_steps[r_wr_ptr] <= steps;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Head of the queue toward the back end.
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd_flags = r_flags[r_rd_ptr];
    assign o_x0        = r_x0[r_rd_ptr];
    assign o_y0        = r_y0[r_rd_ptr];
    assign o_adx       = r_adx[r_rd_ptr];
    assign o_ady       = r_ady[r_rd_ptr];
    assign o_steps     = r_steps[r_rd_ptr];

endmodule

@@ design/lr_divider.sv @@
// ============================================================================
// lr_divider: shared increment divider
// Computes (|dx| << FRAC_BITS) / steps and (|dy| << FRAC_BITS) / steps for
// both axes at once, one quotient bit per cycle, restoring style.
// ============================================================================
module lr_divider
    import lr_pkg::*;
#(
    parameter int COORD_WIDTH = 10,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COORD_WIDTH-1:0] i_num_x,
    input  logic [COORD_WIDTH-1:0] i_num_y,
    input  logic [COORD_WIDTH-1:0] i_den,
    output logic                   o_done,
    output logic [FRAC_BITS:0]     o_quot_x,
    output logic [FRAC_BITS:0]     o_quot_y
);

    localparam int CW    = COORD_WIDTH;
    localparam int QW    = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS);

    logic [CW-1:0]    num     [2];
    logic             init_ge [2];
    logic [CW:0]      trial   [2];
    logic             fit     [2];
    logic [CW-1:0]    n_rem   [2];

    logic [CW-1:0]    r_rem   [2];
    logic [QW-1:0]    r_quot  [2];
    logic [CW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    assign num[0] = i_num_x;
    assign num[1] = i_num_y;

    // One restoring step per lane; the numerator never exceeds the divisor,
    // so the top quotient bit is settled when the unit is loaded.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            init_ge[l] = (num[l] >= i_den);
            trial[l]   = {r_rem[l], 1'b0};
            fit[l]     = (trial[l] >= {1'b0, r_den});
            n_rem[l]   = fit[l] ? CW'(trial[l] - {1'b0, r_den}) : trial[l][CW-1:0];
        end
    end

    // Lane datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
        end
        for (int l = 0; l < 2; l++) begin
            if (i_start) begin
                r_rem[l]  <= init_ge[l] ? (num[l] - i_den) : num[l];
                r_quot[l] <= {{(QW-1){1'b0}}, init_ge[l]};
            end else if (r_busy) begin
                r_rem[l]  <= n_rem[l];
                r_quot[l] <= {r_quot[l][QW-2:0], fit[l]};
            end
        end
    end

    // Iteration counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_quot_x = r_quot[0];
    assign o_quot_y = r_quot[1];

endmodule

@@ design/lr_back.sv @@
// ============================================================================
// lr_back: line stepping engine
// Pops classified requests, keeps the direct-mode error terms and the DDA
// accumulators, and drives the output pixel register.
// ============================================================================
module lr_back
    import lr_pkg::*;
#(
    parameter int COORD_WIDTH = 10,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_alg,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_pop,
    input  t_cmd_flags             i_cmd_flags,
    input  logic [COORD_WIDTH-1:0] i_x0,
    input  logic [COORD_WIDTH-1:0] i_y0,
    input  logic [COORD_WIDTH-1:0] i_adx,
    input  logic [COORD_WIDTH-1:0] i_ady,
    input  logic [COORD_WIDTH-1:0] i_steps,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_WIDTH-1:0] o_pixel_x,
    output logic [COORD_WIDTH-1:0] o_pixel_y,
    output logic                   o_last
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = COORD_WIDTH + FRAC_BITS + 1;
    localparam int EW = COORD_WIDTH + 3;
    localparam int QW = FRAC_BITS + 1;

    t_back_state r_state, n_state;

    // Line state.
    logic                 r_active;
    logic                 r_x_major, r_x_neg, r_y_neg;
    logic [CW-1:0]        r_k, r_total;
    logic [CW-1:0]        r_dir_x, r_dir_y;
    logic [CW-1:0]        r_num, r_den;
    logic                 r_num_neg;
    logic [CW:0]          r_err;
    logic signed [AW-1:0] r_acc_x, r_acc_y;
    logic signed [AW-1:0] r_inc_x, r_inc_y;

    // Output register.
    logic          r_out_valid;
    logic [CW-1:0] r_out_x, r_out_y;
    logic          r_out_last;

    logic                 out_free, div_start, div_done;
    logic                 pop_start, pop_advance;
    logic [QW-1:0]        quot_x, quot_y;
    logic signed [AW-1:0] quot_x_ext, quot_y_ext;
    logic [CW-1:0]        n_k;
    logic signed [EW-1:0] two_num, two_den, err_sum, n_err;
    logic                 minor_up, minor_dn;
    logic [CW-1:0]        major_x, major_y, minor_x, minor_y;
    logic [CW-1:0]        n_dir_x, n_dir_y;
    logic signed [AW-1:0] n_acc_x, n_acc_y;

    lr_divider #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num_x (i_adx),
        .i_num_y (i_ady),
        .i_den   (i_steps),
        .o_done  (div_done),
        .o_quot_x(quot_x),
        .o_quot_y(quot_y)
    );

    assign out_free = !r_out_valid || i_ready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_READY: begin
                if (div_start) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    n_state = ST_READY;
                end
            end
            default: n_state = ST_READY;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_cmd_pop = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            ST_READY: begin
                o_cmd_pop = i_cmd_valid && out_free;
                div_start = o_cmd_pop && i_cmd_flags.is_start && !i_cmd_flags.zero_len;
            end
            ST_DIVIDE: begin
                o_cmd_pop = 1'b0;
                div_start = 1'b0;
            end
            default: begin
                o_cmd_pop = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    assign pop_start   = o_cmd_pop && i_cmd_flags.is_start;
    assign pop_advance = o_cmd_pop && !i_cmd_flags.is_start && r_active;

    // Direct mode: running remainder of (2*num*k + den) / (2*den); the
    // quotient moves by at most one per step, so one correction suffices.
    always_comb begin
        n_k      = r_k + CW'(1);
        two_num  = $signed({2'b00, r_num, 1'b0});
        two_den  = $signed({2'b00, r_den, 1'b0});
        err_sum  = $signed({2'b00, r_err}) + (r_num_neg ? -two_num : two_num);
        minor_up = (err_sum >= two_den);
        minor_dn = (err_sum < 0);
        if (minor_up) begin
            n_err = err_sum - two_den;
        end else if (minor_dn) begin
            n_err = err_sum + two_den;
        end else begin
            n_err = err_sum;
        end
        major_x = r_x_neg ? (r_dir_x - CW'(1)) : (r_dir_x + CW'(1));
        major_y = r_y_neg ? (r_dir_y - CW'(1)) : (r_dir_y + CW'(1));
        minor_x = minor_up ? (r_dir_x + CW'(1)) : (minor_dn ? (r_dir_x - CW'(1)) : r_dir_x);
        minor_y = minor_up ? (r_dir_y + CW'(1)) : (minor_dn ? (r_dir_y - CW'(1)) : r_dir_y);
        n_dir_x = r_x_major ? major_x : minor_x;
        n_dir_y = r_x_major ? minor_y : major_y;
    end

    // DDA: accumulators carry a half-pixel bias, so the pixel is a plain slice.
    assign n_acc_x = r_acc_x + r_inc_x;
    assign n_acc_y = r_acc_y + r_inc_y;

    // Signed increments from the unsigned quotients.
    assign quot_x_ext = $signed({{(AW-QW){1'b0}}, quot_x});
    assign quot_y_ext = $signed({{(AW-QW){1'b0}}, quot_y});

    // Line state update.
    always_ff @(posedge i_clk) begin
        if (pop_start) begin
            r_x_major <= i_cmd_flags.x_major;
            r_x_neg   <= i_cmd_flags.x_neg;
            r_y_neg   <= i_cmd_flags.y_neg;
            r_k       <= '0;
            r_total   <= i_steps;
            r_dir_x   <= i_x0;
            r_dir_y   <= i_y0;
            r_num     <= i_cmd_flags.x_major ? i_ady : i_adx;
            r_den     <= i_cmd_flags.x_major ? i_adx : i_ady;
            r_num_neg <= i_cmd_flags.x_major ? i_cmd_flags.y_neg : i_cmd_flags.x_neg;
            r_err     <= {1'b0, (i_cmd_flags.x_major ? i_adx : i_ady)};
            r_acc_x   <= $signed(AW'({i_x0, 1'b1, {(FRAC_BITS-1){1'b0}}}));
            r_acc_y   <= $signed(AW'({i_y0, 1'b1, {(FRAC_BITS-1){1'b0}}}));
        end else if (pop_advance) begin
            r_k     <= n_k;
            r_dir_x <= n_dir_x;
            r_dir_y <= n_dir_y;
            r_err   <= n_err[CW:0];
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
        end
        if (r_state == ST_DIVIDE && div_done) begin
            r_inc_x <= r_x_neg ? -quot_x_ext : quot_x_ext;
            r_inc_y <= r_y_neg ? -quot_y_ext : quot_y_ext;
        end
    end

    // Output pixel payload.
    always_ff @(posedge i_clk) begin
        if (pop_start) begin
            r_out_x    <= i_x0;
            r_out_y    <= i_y0;
            r_out_last <= i_cmd_flags.zero_len;
        end else if (pop_advance) begin
            r_out_x    <= (i_alg == ALG_DDA) ? n_acc_x[FRAC_BITS +: CW] : n_dir_x;
            r_out_y    <= (i_alg == ALG_DDA) ? n_acc_y[FRAC_BITS +: CW] : n_dir_y;
            r_out_last <= (n_k >= r_total);
        end
    end

    // Control state: sequencer, line activity and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop_start) begin
                r_active <= !i_cmd_flags.zero_len;
            end else if (pop_advance && (n_k >= r_total)) begin
                r_active <= 1'b0;
            end
            if (pop_start || pop_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_pixel_x = r_out_x;
    assign o_pixel_y = r_out_y;
    assign o_last    = r_out_last;

endmodule

@@ design/line_rasterizer_direct_and_dda_unit.sv @@
// ============================================================================
// line_rasterizer_direct_and_dda_unit: line segment to pixel stream
// Top level: input and output streams, the algorithm register, and the
// front end, command queue and stepping engine.
// ============================================================================
// A start request (tuser 0) loads both endpoints, and its first pixel, the
// start point, passes the command queue and then the output register. The
// stepping engine then waits on the shared divider, which forms both DDA
// increments one quotient bit per cycle, and takes the next request once the
// divider is done; the two-entry queue keeps accepting meanwhile. Advance
// requests (tuser 1) return one pixel each at one request per cycle while the
// output is not stalled and no division runs, the last pixel of a line flagged
// on tlast; an advance with no line in progress returns nothing. The algorithm
// register is written through the cfg channel, ready at all times, and is to
// be changed only between requests.
module line_rasterizer_direct_and_dda_unit
    import lr_pkg::*;
#(
    parameter int COORD_WIDTH = 10,
    parameter int FRAC_BITS   = 16,
    localparam int IN_W  = ((4 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // x_start, y_start, x_end, y_end, zero fill
    input  logic             s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // pixel_x, pixel_y, zero fill
    output logic             m_axis_tlast,  // last_pixel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data     // line_algorithm
);

    localparam int CW = COORD_WIDTH;

    logic          r_line_algorithm;
    logic          cmd_valid, cmd_pop;
    t_cmd_flags    cmd_flags;
    logic [CW-1:0] cmd_x0, cmd_y0, cmd_adx, cmd_ady, cmd_steps;
    logic [CW-1:0] pixel_x, pixel_y;

    // Algorithm register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_algorithm <= ALG_DIRECT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_algorithm <= i_cfg_data;
        end
    end

    lr_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .o_cmd_valid(cmd_valid),
        .i_cmd_pop  (cmd_pop),
        .o_cmd_flags(cmd_flags),
        .o_x0       (cmd_x0),
        .o_y0       (cmd_y0),
        .o_adx      (cmd_adx),
        .o_ady      (cmd_ady),
        .o_steps    (cmd_steps)
    );

    lr_back #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_alg      (r_line_algorithm),
        .i_cmd_valid(cmd_valid),
        .o_cmd_pop  (cmd_pop),
        .i_cmd_flags(cmd_flags),
        .i_x0       (cmd_x0),
        .i_y0       (cmd_y0),
        .i_adx      (cmd_adx),
        .i_ady      (cmd_ady),
        .i_steps    (cmd_steps),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_pixel_x  (pixel_x),
        .o_pixel_y  (pixel_y),
        .o_last     (m_axis_tlast)
    );

    // Pack the pixel, x in the low bits.
    assign m_axis_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

@@ design/lr_checker.sv @@
// ============================================================================
// lr_checker: port-level checks of the line rasterizer
// Watches the top-level ports for reset behavior and a stalled result.
// ============================================================================
module lr_checker
    import lr_pkg::*;
#(
    parameter int COORD_WIDTH = 10,
    localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);

    // Reset leaves no pixel pending.
    a_reset_no_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Reset empties the command queue, so requests are taken at once.
    a_reset_queue_open: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // A stalled pixel keeps its coordinates and last flag.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled pixel changed");

endmodule

bind line_rasterizer_direct_and_dda_unit lr_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_lr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

@@ sim/tb_top.sv @@
// ============================================================================
// tb_top: testbench of the line rasterizer
// Drives start and advance requests into the input stream and predicts
// every pixel in both the direct and the DDA mode. Each pixel that leaves
// the output stream is compared field by field with the oldest prediction.
// Both streams idle at random, and the output holds off for a long stretch
// once so that the unit fills up and stalls its input.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import lr_pkg::*;

    localparam int COORD_W        = 10;
    localparam int FRAC_W         = 16;
    localparam int IN_W           = ((4 * COORD_W + 7) / 8) * 8;
    localparam int OUT_W          = ((2 * COORD_W + 7) / 8) * 8;
    localparam int COORD_MAX      = (1 << COORD_W) - 1;
    // Divider time of a start request plus pipeline slack.
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_pixel;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;  // x_start, y_start, x_end, y_end, zero fill
    logic             s_axis_tuser = 1'b0;  // kind
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;  // pixel_x, pixel_y, zero fill
    logic             m_axis_tlast;  // last_pixel
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_data = 1'b0;  // line_algorithm

    line_rasterizer_direct_and_dda_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Pixel predictor state.
    // ------------------------------------------------------------------------
    logic                      line_mode = ALG_DIRECT;
    logic                      line_on = 1'b0;
    logic [10:0]               pos_index = '0;
    logic [10:0]               pos_count = '0;
    logic [COORD_W-1:0]        org_x = '0;
    logic [COORD_W-1:0]        org_y = '0;
    logic signed [COORD_W:0]   span_x = '0;
    logic signed [COORD_W:0]   span_y = '0;
    logic signed [26:0]        acc_x = '0;
    logic signed [26:0]        acc_y = '0;
    logic signed [26:0]        inc_x = '0;
    logic signed [26:0]        inc_y = '0;

    t_pixel pending_pixels[$];
    int     error_count = 0;

    // Sender and receiver idling controls.
    int tx_burst_left = 0;
    bit tx_gapless = 1'b0;
    bit rx_stalls_on = 1'b1;
    int rx_hold_len = 0;

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Floor division for a positive divisor.
    function automatic longint floor_div(input longint n, input longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    // base + num*k/den, rounded half up, computed exactly.
    function automatic longint minor_coord(input longint base, input longint num,
                                           input longint k, input longint den);
        return base + floor_div(2 * num * k + den, 2 * den);
    endfunction

    // Signed Q.FRAC_W step of one axis, truncated toward zero.
    function automatic longint dda_step(input longint d, input longint steps);
        longint m;
        m = (magnitude(d) << FRAC_W) / steps;
        return (d < 0) ? -m : m;
    endfunction

    // Pixel at the current step, in the mode the register holds right now.
    function automatic t_pixel current_pixel();
        longint adx, ady, k, px, py;
        t_pixel p;
        adx = magnitude(longint'(span_x));
        ady = magnitude(longint'(span_y));
        k   = longint'(pos_index);
        if (line_mode == ALG_DDA) begin
            px = (longint'(acc_x) + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
            py = (longint'(acc_y) + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
        end else if (adx == 0 && ady == 0) begin
            px = longint'(org_x);
            py = longint'(org_y);
        end else if (ady <= adx) begin
            px = longint'(org_x) + ((span_x > 0) ? k : -k);
            py = minor_coord(longint'(org_y), longint'(span_y), k, adx);
        end else begin
            py = longint'(org_y) + ((span_y > 0) ? k : -k);
            px = minor_coord(longint'(org_x), longint'(span_x), k, ady);
        end
        p.x    = px[COORD_W-1:0];
        p.y    = py[COORD_W-1:0];
        p.last = (pos_index >= pos_count);
        return p;
    endfunction

    // Updates the line state for one accepted request and queues its pixel.
    task automatic predict_request(input logic kind, input logic [IN_W-1:0] data);
        longint x0, y0, x1, y1, adx, ady, steps;
        t_pixel p;
        if (kind == KIND_START) begin
            x0 = longint'(data[0*COORD_W +: COORD_W]);
            y0 = longint'(data[1*COORD_W +: COORD_W]);
            x1 = longint'(data[2*COORD_W +: COORD_W]);
            y1 = longint'(data[3*COORD_W +: COORD_W]);
            adx = magnitude(x1 - x0);
            ady = magnitude(y1 - y0);
            steps = (adx > ady) ? adx : ady;
            org_x = x0[COORD_W-1:0];
            org_y = y0[COORD_W-1:0];
            span_x = x1[COORD_W:0] - x0[COORD_W:0];
            span_y = y1[COORD_W:0] - y0[COORD_W:0];
            pos_count = steps[10:0];
            pos_index = '0;
            acc_x = 27'(x0 << FRAC_W);
            acc_y = 27'(y0 << FRAC_W);
            inc_x = 27'((steps > 0) ? dda_step(x1 - x0, steps) : longint'(0));
            inc_y = 27'((steps > 0) ? dda_step(y1 - y0, steps) : longint'(0));
            line_on = 1'b1;
        end else begin
            // An advance with no line in progress is dropped.
            if (!line_on)
                return;
            pos_index = pos_index + 1'b1;
            acc_x = acc_x + inc_x;
            acc_y = acc_y + inc_y;
        end
        p = current_pixel();
        pending_pixels.insert(pending_pixels.size(), p);
        if (p.last)
            line_on = 1'b0;
    endtask

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predicts on each accepted request, checks each pixel and
    // watches for a stalled run.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : monitor_proc
        t_pixel got, want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                line_mode = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got.x    = m_axis_tdata[0 +: COORD_W];
                got.y    = m_axis_tdata[COORD_W +: COORD_W];
                got.last = m_axis_tlast;
                if (pending_pixels.size() == 0) begin
                    note_failure($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                           got.x, got.y, got.last));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.last !== want.last)
                        note_failure($sformatf(
                            "pixel expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                            want.x, want.y, want.last, got.x, got.y, got.last));
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request or pixel moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: alternating ready and stall runs of random length, and a
    // long hold-off when a test asks for one.
    // ------------------------------------------------------------------------
    int rx_hold_left = 0;
    int rx_run = 0;
    bit rx_stall = 1'b0;

    always @(posedge i_clk) begin
        if (rx_hold_len != 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_run == 0) begin
                rx_stall = rx_stalls_on && !rx_stall;
                rx_run   = rx_stall ? $urandom_range(1, 6) : $urandom_range(1, 20);
            end
            rx_run--;
            m_axis_tready <= !rx_stall;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_request(input logic kind, input logic [IN_W-1:0] data);
        int gap;
        if (tx_burst_left == 0) begin
            gap = tx_gapless ? 0 : $urandom_range(0, 8);
            tx_burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        tx_burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_start(input int xs, input int ys, input int xe, input int ye);
        logic [IN_W-1:0] data;
        data = '0;
        data[0*COORD_W +: COORD_W] = xs[COORD_W-1:0];
        data[1*COORD_W +: COORD_W] = ys[COORD_W-1:0];
        data[2*COORD_W +: COORD_W] = xe[COORD_W-1:0];
        data[3*COORD_W +: COORD_W] = ye[COORD_W-1:0];
        send_request(KIND_START, data);
    endtask

    // Advances carry random endpoint bits, which the unit must ignore.
    task automatic send_advance(input int count);
        repeat (count) send_request(KIND_ADVANCE, IN_W'({$urandom, $urandom}));
    endtask

    // Waits until every predicted pixel has arrived, then lets the unit settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_algorithm(input logic alg);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= alg;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int any_coord();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return COORD_MAX;
            default: return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    function automatic int nearby(input int base);
        int v;
        v = base + int'($urandom_range(0, 24)) - 12;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Direct mode: idle advances, zero length, axis-aligned lines, a half
    // rounding step, the full diagonal and a restart while a line runs.
    task automatic test_direct_cases();
        write_algorithm(ALG_DIRECT);
        send_advance(1);
        send_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_advance(1);
        send_start(COORD_MAX - 3, 0, COORD_MAX, 0);
        send_advance(3);
        send_start(0, COORD_MAX, 0, COORD_MAX - 3);
        send_advance(3);
        send_start(0, 0, 4, 1);
        send_advance(2);
        send_start(0, 0, COORD_MAX, COORD_MAX);
        send_advance(1);
        send_start(5, 9, 2, 1);
        send_advance(8);
        wait_idle();
    endtask

    // DDA mode: negative slope with half steps, the opposite diagonal cut
    // short, and a zero-length restart.
    task automatic test_dda_cases();
        write_algorithm(ALG_DDA);
        send_start(0, 1, 4, 0);
        send_advance(4);
        send_start(COORD_MAX, 0, 0, COORD_MAX);
        send_advance(1);
        send_start(512, 512, 512, 512);
        send_advance(1);
        wait_idle();
    endtask

    // The register changes twice while one steep line is in progress.
    task automatic test_mode_switch();
        write_algorithm(ALG_DIRECT);
        send_start(0, 0, 3, 7);
        send_advance(1);
        wait_idle();
        write_algorithm(ALG_DDA);
        send_advance(2);
        wait_idle();
        write_algorithm(ALG_DIRECT);
        send_advance(5);
        wait_idle();
    endtask

    // The receiver holds off while a whole line is offered back to back.
    task automatic test_backpressure();
        tx_gapless   = 1'b1;
        rx_stalls_on = 1'b0;
        write_algorithm(ALG_DDA);
        rx_hold_len = RX_HOLD_CYCLES;
        send_start(0, 0, 30, 13);
        send_advance(30);
        wait_idle();
        tx_gapless   = 1'b0;
        rx_stalls_on = 1'b1;
    endtask

    // Mostly short complete lines with random content; some are cut short
    // by the next start and some are followed by advances with no line.
    task automatic test_random_lines(input logic alg, input int quota, input bit idling);
        int xs, ys, xe, ye, steps, adv, sent;
        tx_gapless   = !idling;
        rx_stalls_on = idling;
        write_algorithm(alg);
        sent = 0;
        while (sent < quota) begin
            xs = any_coord();
            ys = any_coord();
            if ($urandom_range(0, 4) == 0) begin
                xe = any_coord();
                ye = any_coord();
            end else begin
                xe = nearby(xs);
                ye = nearby(ys);
            end
            steps = (xe > xs) ? xe - xs : xs - xe;
            if (((ye > ys) ? ye - ys : ys - ye) > steps)
                steps = (ye > ys) ? ye - ys : ys - ye;
            send_start(xs, ys, xe, ye);
            sent++;
            case ($urandom_range(0, 7))
                0:       adv = $urandom_range(0, (steps < 20) ? steps : 20);
                1:       adv = steps + $urandom_range(1, 3);
                default: adv = (steps > 40) ? $urandom_range(0, 40) : steps;
            endcase
            for (int k = 0; k < adv; k++) begin
                send_advance(1);
                if (k < steps)
                    sent++;
            end
        end
        wait_idle();
        tx_gapless   = 1'b0;
        rx_stalls_on = 1'b1;
    endtask

    // One line across the whole range, where DDA truncation adds up.
    task automatic test_long_line();
        write_algorithm(ALG_DDA);
        send_start(0, COORD_MAX, COORD_MAX, 300);
        send_advance(COORD_MAX);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_direct_cases();
        test_dda_cases();
        test_mode_switch();
        test_backpressure();
        test_random_lines(ALG_DIRECT, 200, 1'b1);
        test_random_lines(ALG_DDA, 200, 1'b1);
        test_random_lines(ALG_DIRECT, 100, 1'b0);
        test_random_lines(ALG_DDA, 100, 1'b0);
        test_long_line();
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/lr_pkg.sv
design/lr_front.sv
design/lr_divider.sv
design/lr_back.sv
design/line_rasterizer_direct_and_dda_unit.sv
design/lr_checker.sv
sim/tb_top.sv
